### hdl/ece_pkg.sv
// package: formats, curve codes, sine and exp2 tables, lookup result type
`timescale 1ns / 1ps
package ece_pkg;

   localparam int FRAC_BITS        = 16;
   localparam int SINE_TABLE_DEPTH = 256;
   localparam int EXP_TABLE_DEPTH  = 256;
   localparam int TAB_BITS         = 30;
   localparam int SIN_LOG          = $clog2(SINE_TABLE_DEPTH);
   localparam int EXP_LOG          = $clog2(EXP_TABLE_DEPTH);
   localparam int TQ_SHIFT         = TAB_BITS - FRAC_BITS;

   localparam logic [63:0] HALF_PI_TAB = 64'd1686629713;
   localparam logic [63:0] LN2_TAB     = 64'd744261118;
   localparam logic [63:0] TAB_ONE     = 64'd1 << TAB_BITS;

   localparam logic [16:0] ONE  = 17'h10000;
   localparam logic [16:0] HALF = 17'h08000;

   // curve selector codes
   localparam logic [4:0] FN_LINEAR       = 5'd0;
   localparam logic [4:0] FN_SINE_IN      = 5'd1;
   localparam logic [4:0] FN_SINE_OUT     = 5'd2;
   localparam logic [4:0] FN_SINE_INOUT   = 5'd3;
   localparam logic [4:0] FN_QUAD_IN      = 5'd4;
   localparam logic [4:0] FN_QUAD_INOUT   = 5'd6;
   localparam logic [4:0] FN_CUBIC_IN     = 5'd7;
   localparam logic [4:0] FN_CUBIC_INOUT  = 5'd9;
   localparam logic [4:0] FN_QUART_IN     = 5'd10;
   localparam logic [4:0] FN_QUART_INOUT  = 5'd12;
   localparam logic [4:0] FN_QUINT_IN     = 5'd13;
   localparam logic [4:0] FN_QUINT_INOUT  = 5'd15;
   localparam logic [4:0] FN_EXPO_IN      = 5'd16;
   localparam logic [4:0] FN_EXPO_OUT     = 5'd17;
   localparam logic [4:0] FN_EXPO_INOUT   = 5'd18;

   // polynomial variants
   localparam logic [1:0] KIND_IN    = 2'd0;
   localparam logic [1:0] KIND_OUT   = 2'd1;
   localparam logic [1:0] KIND_INOUT = 2'd2;

   typedef logic [30:0] sine_tab_type [0:SINE_TABLE_DEPTH];
   typedef logic [30:0] exp_tab_type  [0:EXP_TABLE_DEPTH];

   typedef struct packed {
      logic [30:0] a;
      logic [30:0] d;
      logic        neg;
      logic [15:0] frac;
   } lk_type;

   function automatic logic [30:0] sin_series(logic [63:0] x);
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] sum;
      x2   = (x * x) >> TAB_BITS;
      term = x;
      sum  = x;
      for (int k = 1; k <= 7; k++) begin
         term = ((term * x2) >> TAB_BITS) / 64'((2 * k) * (2 * k + 1));
         if (k % 2 == 1) begin
            sum = (term > sum) ? 64'd0 : sum - term;
         end else begin
            sum = sum + term;
         end
      end
      if (sum > TAB_ONE) begin
         sum = TAB_ONE;
      end
      return sum[30:0];
   endfunction

   function automatic logic [30:0] expneg_series(logic [63:0] y);
      logic [63:0] term;
      logic [63:0] sum;
      term = TAB_ONE;
      sum  = TAB_ONE;
      for (int k = 1; k <= 14; k++) begin
         term = ((term * y) >> TAB_BITS) / 64'(k);
         if (k % 2 == 1) begin
            sum = (term > sum) ? 64'd0 : sum - term;
         end else begin
            sum = sum + term;
         end
      end
      return sum[30:0];
   endfunction

   function automatic sine_tab_type build_sine();
      sine_tab_type tab;
      for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
         tab[i] = sin_series((HALF_PI_TAB * 64'(i)) / SINE_TABLE_DEPTH);
      end
      return tab;
   endfunction

   function automatic exp_tab_type build_exp();
      exp_tab_type tab;
      for (int i = 0; i <= EXP_TABLE_DEPTH; i++) begin
         tab[i] = expneg_series((LN2_TAB * 64'(i)) / EXP_TABLE_DEPTH);
      end
      return tab;
   endfunction

   localparam sine_tab_type SINE_TAB = build_sine();
   localparam exp_tab_type  EXP_TAB  = build_exp();

endpackage

### hdl/ece_lookup.sv
// table read for sine and 2^-x: neighbor entries, step and interpolation fraction
`timescale 1ns / 1ps
module ece_lookup import ece_pkg::*; (
   input  logic        sel_exp,
   input  logic [16:0] u,
   output lk_type      lk
);

   logic [SIN_LOG:0] s_idx;
   logic [SIN_LOG:0] s_nxt;
   logic [EXP_LOG:0] e_idx;
   logic [EXP_LOG:0] e_nxt;
   logic [30:0]      a;
   logic [30:0]      b;
   logic [15:0]      frac;

   always_comb begin
      s_idx = u[FRAC_BITS -: SIN_LOG + 1];
      e_idx = u[FRAC_BITS -: EXP_LOG + 1];
      // index equal to depth only at u = one: no upper neighbor
      s_nxt = s_idx[SIN_LOG] ? s_idx : s_idx + 1'b1;
      e_nxt = e_idx[EXP_LOG] ? e_idx : e_idx + 1'b1;
      if (sel_exp) begin
         a    = EXP_TAB[e_idx];
         b    = EXP_TAB[e_nxt];
         frac = {u[FRAC_BITS-EXP_LOG-1:0], EXP_LOG'(0)};
      end else begin
         a    = SINE_TAB[s_idx];
         b    = SINE_TAB[s_nxt];
         frac = {u[FRAC_BITS-SIN_LOG-1:0], SIN_LOG'(0)};
      end
      lk.a    = a;
      lk.neg  = b < a;
      lk.d    = (b < a) ? a - b : b - a;
      lk.frac = frac;
   end

endmodule

### hdl/easing_curve_evaluator.sv
// easing curve evaluator top level: six-stage pipeline with per-stage flow control
`timescale 1ns / 1ps
// an accepted item passes stage registers 1 to 5 and then the output register before rsp_valid
// throughput: one item per cycle unless the output stalls; the sine/exp2 path is lookup,
// multiply, round, combine and the power chain uses one 17x17 rounded product per stage
// stalls propagate stage by stage, so bubbles are squeezed out while the output waits
// reset (synchronous, active high) clears all stage valid bits; tables are constants
module easing_curve_evaluator import ece_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [17:0] req_time_in,
   input  logic [4:0]  req_func,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [16:0] rsp_eased_value
);

   typedef struct packed {
      logic [4:0]  func;
      logic [16:0] t;
      logic [16:0] x;
      logic [16:0] r;
      logic [2:0]  n;
      logic [1:0]  kind;
      logic [4:0]  sh;
      logic [16:0] u;
      logic        neg;
      logic [30:0] a;
      logic [46:0] d;
      logic [15:0] frac;
      logic [16:0] q;
   } stg_type;

   stg_type     stg_ff [1:5];
   stg_type     stg_in [1:5];
   logic [5:1]  v_ff;
   logic [6:1]  en;
   logic        out_v_ff;
   logic [16:0] out_ff;
   logic [16:0] out_in;
   lk_type      lk;

   function automatic logic [16:0] mulq(logic [16:0] a, logic [16:0] b);
      logic [33:0] p;
      p = 34'(a) * 34'(b) + 34'(HALF);
      return 17'(p >> FRAC_BITS);
   endfunction

   function automatic logic [16:0] halve(logic [17:0] x);
      logic [17:0] s;
      s = x + 18'd1;
      return s[17:1];
   endfunction

   // flow control
   always_comb begin
      en[6] = !out_v_ff || !rsp_stall;
      for (int k = 5; k >= 1; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
   end

   assign req_stall       = !en[1];
   assign rsp_valid       = out_v_ff;
   assign rsp_eased_value = out_ff;

   // stage 1: clamp, decode, curve arguments
   always_comb begin
      logic [16:0] t;
      logic [17:0] t2;
      logic        hi;
      logic [20:0] m;
      stg_in[1] = '0;
      if (req_time_in[17]) begin
         t = '0;
      end else if (req_time_in[16:0] > ONE) begin
         t = ONE;
      end else begin
         t = req_time_in[16:0];
      end
      t2 = {t, 1'b0};
      hi = t >= HALF;
      m  = '0;
      stg_in[1].func = req_func;
      stg_in[1].t    = t;
      stg_in[1].sh   = 5'(TQ_SHIFT);
      case (req_func) inside
         FN_SINE_IN:    stg_in[1].u = ONE - t;
         FN_SINE_OUT:   stg_in[1].u = t;
         FN_SINE_INOUT: stg_in[1].u = hi ? 17'(t2 - 18'(ONE)) : 17'(18'(ONE) - t2);
         [FN_QUAD_IN:FN_QUINT_INOUT]: begin
            case (req_func) inside
               [FN_QUAD_IN:FN_QUAD_INOUT]:   stg_in[1].n = 3'd2;
               [FN_CUBIC_IN:FN_CUBIC_INOUT]: stg_in[1].n = 3'd3;
               [FN_QUART_IN:FN_QUART_INOUT]: stg_in[1].n = 3'd4;
               default:                      stg_in[1].n = 3'd5;
            endcase
            case (req_func) inside
               FN_QUAD_IN, FN_CUBIC_IN, FN_QUART_IN, FN_QUINT_IN:
                  stg_in[1].kind = KIND_IN;
               FN_QUAD_INOUT, FN_CUBIC_INOUT, FN_QUART_INOUT, FN_QUINT_INOUT:
                  stg_in[1].kind = KIND_INOUT;
               default:
                  stg_in[1].kind = KIND_OUT;
            endcase
            case (stg_in[1].kind)
               KIND_IN:  stg_in[1].x = t;
               KIND_OUT: stg_in[1].x = ONE - t;
               default:  stg_in[1].x = hi ? 17'({ONE, 1'b0} - t2) : 17'(t2);
            endcase
            stg_in[1].r = stg_in[1].x;
         end
         FN_EXPO_IN, FN_EXPO_OUT, FN_EXPO_INOUT: begin
            case (req_func)
               FN_EXPO_IN:  m = 21'(ONE - t) * 21'd10;
               FN_EXPO_OUT: m = 21'(t) * 21'd10;
               default:
                  m = hi ? 21'(t) * 21'd20 - 21'(ONE) * 21'd9
                         : 21'(ONE) * 21'd11 - 21'(t) * 21'd20;
            endcase
            stg_in[1].u  = {1'b0, m[15:0]};
            stg_in[1].sh = 5'(TQ_SHIFT) + m[20:16];
         end
         default: stg_in[1].u = '0;
      endcase
   end

   ece_lookup u_lookup (
      .sel_exp (stg_ff[1].func >= FN_EXPO_IN),
      .u       (stg_ff[1].u),
      .lk      (lk)
   );

   // stage 2: table read, first product
   always_comb begin
      stg_in[2]      = stg_ff[1];
      stg_in[2].a    = lk.a;
      stg_in[2].d    = 47'(lk.d);
      stg_in[2].neg  = lk.neg;
      stg_in[2].frac = lk.frac;
      if (stg_ff[1].n >= 3'd2) begin
         stg_in[2].r = mulq(stg_ff[1].r, stg_ff[1].x);
      end
   end

   // stage 3: interpolation product, second power product
   always_comb begin
      stg_in[3]   = stg_ff[2];
      stg_in[3].d = 47'(stg_ff[2].d[30:0]) * 47'(stg_ff[2].frac);
      if (stg_ff[2].n >= 3'd3) begin
         stg_in[3].r = mulq(stg_ff[2].r, stg_ff[2].x);
      end
   end

   // stage 4: apply step, round table value to output scale, third power product
   always_comb begin
      logic [31:0] delta;
      logic [31:0] v;
      logic [31:0] qv;
      stg_in[4] = stg_ff[3];
      delta = 32'((stg_ff[3].d + 47'(HALF)) >> FRAC_BITS);
      v  = stg_ff[3].neg ? 32'(stg_ff[3].a) - delta : 32'(stg_ff[3].a) + delta;
      qv = (v + (32'd1 << (stg_ff[3].sh - 5'd1))) >> stg_ff[3].sh;
      stg_in[4].q = (qv > 32'(ONE)) ? ONE : qv[16:0];
      if (stg_ff[3].n >= 3'd4) begin
         stg_in[4].r = mulq(stg_ff[3].r, stg_ff[3].x);
      end
   end

   // stage 5: last power product
   always_comb begin
      stg_in[5] = stg_ff[4];
      if (stg_ff[4].n >= 3'd5) begin
         stg_in[5].r = mulq(stg_ff[4].r, stg_ff[4].x);
      end
   end

   // output stage: per-curve combine and limit to one
   always_comb begin
      stg_type     s;
      logic        lo;
      logic [16:0] res;
      s   = stg_ff[5];
      lo  = s.t < HALF;
      res = '0;
      case (s.func) inside
         FN_LINEAR:     res = s.t;
         FN_SINE_IN:    res = ONE - s.q;
         FN_SINE_OUT:   res = s.q;
         FN_SINE_INOUT: res = lo ? halve(18'(ONE - s.q)) : halve(18'(ONE) + 18'(s.q));
         [FN_QUAD_IN:FN_QUINT_INOUT]: begin
            case (s.kind)
               KIND_IN:  res = s.r;
               KIND_OUT: res = ONE - s.r;
               default:  res = lo ? halve(18'(s.r)) : ONE - halve(18'(s.r));
            endcase
         end
         FN_EXPO_IN:  res = (s.t == '0) ? '0 : s.q;
         FN_EXPO_OUT: res = (s.t == ONE) ? ONE : ONE - s.q;
         FN_EXPO_INOUT: begin
            if (s.t == '0) begin
               res = '0;
            end else if (s.t == ONE) begin
               res = ONE;
            end else begin
               res = lo ? s.q : ONE - s.q;
            end
         end
         default: res = '0;
      endcase
      out_in = (res > ONE) ? ONE : res;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff     <= '0;
         out_v_ff <= 1'b0;
      end else begin
         if (en[1]) begin
            v_ff[1] <= req_valid;
         end
         for (int k = 2; k <= 5; k++) begin
            if (en[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
         if (en[6]) begin
            out_v_ff <= v_ff[5];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 1; k <= 5; k++) begin
         if (en[k]) begin
            stg_ff[k] <= stg_in[k];
         end
      end
      if (en[6]) begin
         out_ff <= out_in;
      end
   end

endmodule

### hdl/ece_checker.sv
// port-level checker for the easing curve evaluator, bound to the top level
`timescale 1ns / 1ps
module ece_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [16:0] rsp_eased_value
);

   // result never exceeds one
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_eased_value <= 17'h10000)
      else $error("eased value above one");

   // input only backs up when the output is held
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled while output free");

   // stalled item holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_eased_value))
      else $error("stalled item changed");

   // nothing comes out and the input is not stalled right after reset
   a_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid && !req_stall)
      else $error("output valid after reset");

endmodule

bind easing_curve_evaluator ece_checker u_ece_checker (.*);

### bench/easing_curve_evaluator_tb.sv
// testbench for the easing curve evaluator: random and directed items checked by a scoreboard
`timescale 1ns / 1ps
module easing_curve_evaluator_tb import ece_pkg::*; ;

   localparam int ITEM_COUNT = 1850;
   localparam longint CYCLE_LIMIT = 400000;

   // fixed-point easing math, written as its own predictor
   class ease_scoreboard;
      logic [63:0] sin_q30 [0:SINE_TABLE_DEPTH];
      logic [63:0] exp_q30 [0:EXP_TABLE_DEPTH];
      logic [16:0] pending [$];
      int errors;
      int checked;

      function new();
         logic [63:0] x, x2, term, sum, y;
         errors = 0;
         checked = 0;
         for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
            x = (64'd1686629713 * 64'(i)) / 64'(SINE_TABLE_DEPTH);
            x2 = (x * x) >> 30;
            term = x;
            sum = x;
            for (int k = 1; k <= 7; k++) begin
               term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
               if (k % 2 == 1) sum = (term > sum) ? 64'd0 : sum - term;
               else sum = sum + term;
            end
            sin_q30[i] = (sum > (64'd1 << 30)) ? (64'd1 << 30) : sum;
         end
         for (int i = 0; i <= EXP_TABLE_DEPTH; i++) begin
            y = (64'd744261118 * 64'(i)) / 64'(EXP_TABLE_DEPTH);
            term = 64'd1 << 30;
            sum = term;
            for (int k = 1; k <= 14; k++) begin
               term = ((term * y) >> 30) / 64'(k);
               if (k % 2 == 1) sum = (term > sum) ? 64'd0 : sum - term;
               else sum = sum + term;
            end
            exp_q30[i] = sum;
         end
      endfunction

      function logic [63:0] interp(bit use_sine, logic [63:0] u);
         logic [63:0] pos, idx, frac, a, b;
         int depth;
         depth = use_sine ? SINE_TABLE_DEPTH : EXP_TABLE_DEPTH;
         pos = u * 64'(depth);
         idx = pos >> 16;
         frac = pos & 64'hFFFF;
         if (idx >= 64'(depth)) return use_sine ? sin_q30[depth] : exp_q30[depth];
         a = use_sine ? sin_q30[idx] : exp_q30[idx];
         b = use_sine ? sin_q30[idx + 1] : exp_q30[idx + 1];
         if (b >= a) return a + (((b - a) * frac + 64'h8000) >> 16);
         return a - (((a - b) * frac + 64'h8000) >> 16);
      endfunction

      function logic [63:0] to_q16(logic [63:0] v, logic [63:0] extra);
         logic [63:0] s, r;
         s = 64'd14 + extra;
         if (s >= 63) return 0;
         r = (v + (64'd1 << (s - 1))) >> s;
         return r > 64'h10000 ? 64'h10000 : r;
      endfunction

      function logic [63:0] sine16(logic [63:0] u);
         return to_q16(interp(1, u), 0);
      endfunction

      function logic [63:0] exp2neg(logic [63:0] m);
         return to_q16(interp(0, m & 64'hFFFF), m >> 16);
      endfunction

      function logic [63:0] power(logic [63:0] x, int n);
         logic [63:0] r;
         r = x;
         for (int i = 1; i < n; i++) r = (r * x + 64'h8000) >> 16;
         return r;
      endfunction

      function logic [63:0] curve(logic [63:0] t, logic [4:0] f);
         int n, kind;
         logic [63:0] one;
         one = 64'h10000;
         if (f == FN_LINEAR) return t;
         if (f == FN_SINE_IN) return one - sine16(one - t);
         if (f == FN_SINE_OUT) return sine16(t);
         if (f == FN_SINE_INOUT) begin
            if (t < 64'h8000) return (one - sine16(one - 2 * t) + 1) >> 1;
            return (one + sine16(2 * t - one) + 1) >> 1;
         end
         if (f <= FN_QUINT_INOUT) begin
            n = 2 + (int'(f) - 4) / 3;
            kind = (int'(f) - 4) % 3;
            if (kind == KIND_IN) return power(t, n);
            if (kind == KIND_OUT) return one - power(one - t, n);
            if (t < 64'h8000) return (power(2 * t, n) + 1) >> 1;
            return one - ((power(2 * one - 2 * t, n) + 1) >> 1);
         end
         if (f == FN_EXPO_IN) return t == 0 ? 0 : exp2neg(10 * (one - t));
         if (f == FN_EXPO_OUT) return t == one ? one : one - exp2neg(10 * t);
         if (f == FN_EXPO_INOUT) begin
            if (t == 0) return 0;
            if (t == one) return one;
            if (t < 64'h8000) return exp2neg(11 * one - 20 * t);
            return one - exp2neg(20 * t - 9 * one);
         end
         return 0;
      endfunction

      function void note_item(logic [17:0] tm, logic [4:0] f);
         logic [63:0] t, r;
         if (tm[17]) t = 0;
         else t = (tm > 18'h10000) ? 64'h10000 : 64'(tm);
         r = curve(t, f);
         if (r > 64'h10000) r = 64'h10000;
         pending.push_back(r[16:0]);
      endfunction

      function void check_result(logic [16:0] got);
         logic [16:0] want;
         checked++;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result eased_value=%0d", $time, got);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got !== want) begin
            $display("%0t: eased_value mismatch expected=%0d actual=%0d", $time, want, got);
            errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [17:0] req_time_in;
   logic [4:0]  req_func;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [16:0] rsp_eased_value;

   ease_scoreboard board;
   int  send_idle_pct;
   int  recv_stall_pct;
   longint cycles;
   int  sent;

   easing_curve_evaluator u_top (.*);

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // scoreboard updates and timeout at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) board.note_item(req_time_in, req_func);
         if (rsp_valid && !rsp_stall) board.check_result(rsp_eased_value);
      end
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("Simulation FAILED");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   // present one item, hold it until taken; valid drops only in idle cycles
   task automatic send_item(logic [17:0] tm, logic [4:0] f);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_time_in <= tm;
      req_func <= f;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      sent++;
   endtask

   function automatic logic [17:0] pick_time();
      int r;
      r = $urandom_range(99);
      if (r < 70) return 18'($urandom_range(65536));
      if (r < 80) return 18'($urandom_range(32800, 32736));
      if (r < 88) return 18'($urandom_range(5)) | (($urandom_range(1)) ? 18'h10000 - 18'($urandom_range(5)) : 18'h0);
      return 18'($urandom);
   endfunction

   initial begin
      logic [17:0] edge_times [9];
      board = new();
      cycles = 0;
      sent = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_time_in = '0;
      req_func = '0;
      rsp_stall = 1'b0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      edge_times = '{18'h20000, 18'h3FFFF, 18'h0, 18'h1, 18'h7FFF, 18'h8000,
                     18'hFFFF, 18'h10000, 18'h1FFFF};
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // each selector 0 to 18 at one of the clamp-edge and midpoint times in turn, plus out-of-range selectors
      for (int f = 0; f <= 18; f++) send_item(edge_times[f % 9], 5'(f));
      send_item(18'h4000, 5'd19);
      send_item(18'h2AAAA, 5'd31);
      send_item(18'h15555, 5'd21);

      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = (ph == 1 || ph == 3) ? 69 : (ph == 3 ? 11 : 0);
         recv_stall_pct = (ph == 2) ? 69 : 0;
         if (ph == 3) begin
            send_idle_pct = 11;
            recv_stall_pct = 11;
         end
         for (int i = 0; i < ITEM_COUNT / 4; i++)
            send_item(pick_time(), ($urandom_range(99) < 95) ? 5'($urandom_range(18))
                                                             : 5'($urandom));
      end
      req_valid <= 1'b0;

      while (board.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("sent %0d items over all 19 curves, clamp edges and bad selectors", sent);
      $display("checked %0d results under four idle/stall mixes", board.checked);
      if (board.errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule
